>>> hdl/lht_pkg.sv
// Shared types, codes and defaults for the linear hash table.
// Used by lht_ctrl, lht_dp and linear_hash_table; no dependencies.
package lht_pkg;

    localparam int MAX_BUCKETS_DEF = 256;
    localparam int CHAIN_CAP_DEF   = 64;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 9;

    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_BUCKETS = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BUCKET_ENTRIES  = 4'd1;

    localparam logic [1:0] OP_INSERT  = 2'd0;
    localparam logic [1:0] OP_LOOKUP  = 2'd1;
    localparam logic [1:0] OP_EXTRACT = 2'd2;
    localparam logic [1:0] OP_COUNT   = 2'd3;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND  = 2'd1;
    localparam logic [1:0] ST_CHAIN_FULL = 2'd2;
    localparam logic [1:0] ST_TABLE_FULL = 2'd3;

    localparam logic [14:0] COUNT_MAX = 15'h7FFF;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] key;
        logic [30:0] key_hash;
        logic [31:0] item_value;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] found_item;
        logic [14:0] stored_count;
    } t_out;

    typedef struct packed {
        logic [31:0] key;
        logic [30:0] hash;
        logic [31:0] item;
    } t_slot;

    // Controller to datapath
    typedef struct packed {
        logic clr;
        logic load;
        logic home;
        logic hlen;
        logic ins;
        logic scan;
        logic xlast;
        logic xmove;
        logic spl0;
        logic spl1;
        logic srd;
        logic sdat;
        logic swr;
        logic sfin0;
        logic sfin1;
        logic resp;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic       cfg_hit;
        logic       clr_last;
        logic       div_busy;
        logic [1:0] op;
        logic       scan_hit;
        logic       scan_end;
        logic       ins_split;
        logic       split_end;
        logic       out_free;
    } t_sts;

endpackage

>>> hdl/linear_hash_table.sv
// Top level of the linear-hashing key/item table.
// Depends on lht_pkg, lht_ctrl, lht_dp (which holds two lht_ram instances).
//
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+------------------------------
//  in       | input     | i_in_valid / o_in_ready   | i_in  (t_in: op, key, hash, item)
//  out      | output    | o_out_valid / i_out_ready | o_out (t_out: status, item, count)
//  cfg      | input     | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// One transaction at a time. Home bucket: a run of the modulo unit (four
// remainder bits a cycle) and then the control states. Lookup and extract
// walk the chain slot by slot (up to CHAIN_CAP), and extract then moves the last slot.
// A split costs, for each entry of the split bucket, one slot RAM read
// and one run of the shared modulo unit.
// After reset and after each write to REG_INITIAL_BUCKETS or REG_BUCKET_ENTRIES, a
// pass over all buckets zeroes the chain length memory; no transaction is taken then.
// The result register holds a finished result while the next transaction is
// accepted; a stalled output only holds the block at its final step.
module linear_hash_table import lht_pkg::*; #(
    parameter int MAX_BUCKETS = MAX_BUCKETS_DEF,
    parameter int CHAIN_CAP   = CHAIN_CAP_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in                   i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out                  o_out,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd cmd;
    t_sts sts;

    // the user writes configuration only while idle; not enforced here: always take it
    assign o_cfg_ready = 1'b1;

    lht_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    lht_dp #(
        .MAX_BUCKETS (MAX_BUCKETS),
        .CHAIN_CAP   (CHAIN_CAP)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (i_in),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out       (o_out),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

    // drop ready for the cycle after a transaction is taken
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken while previous transaction in flight");

    // a failed operation never returns an item
    a_no_item_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.status != ST_OK) |-> (o_out.found_item == 32'd0))
        else $error("item returned with failing status");

    // the count never exceeds the slot storage
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (32'(o_out.stored_count) <= MAX_BUCKETS * CHAIN_CAP))
        else $error("stored count beyond capacity");

    // a result load never collides with a new transaction
    a_resp_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.resp |-> !(i_in_valid && o_in_ready))
        else $error("result issued while accepting");

endmodule

>>> hdl/lht_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/lht_ctrl.sv
// Sequencing state machine of the linear hash table.
// Depends on lht_pkg (t_cmd, t_sts, operation codes).
module lht_ctrl import lht_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [4:0] S_CLEAR = 5'd0;
    localparam logic [4:0] S_IDLE  = 5'd1;
    localparam logic [4:0] S_HDIV  = 5'd2;
    localparam logic [4:0] S_HOME  = 5'd3;
    localparam logic [4:0] S_HLEN  = 5'd4;
    localparam logic [4:0] S_INS   = 5'd5;
    localparam logic [4:0] S_SCAN  = 5'd6;
    localparam logic [4:0] S_XLAST = 5'd7;
    localparam logic [4:0] S_XMOVE = 5'd8;
    localparam logic [4:0] S_SPL0  = 5'd9;
    localparam logic [4:0] S_SPL1  = 5'd10;
    localparam logic [4:0] S_SRD   = 5'd11;
    localparam logic [4:0] S_SDAT  = 5'd12;
    localparam logic [4:0] S_SDIV  = 5'd13;
    localparam logic [4:0] S_SWR   = 5'd14;
    localparam logic [4:0] S_SFIN0 = 5'd15;
    localparam logic [4:0] S_SFIN1 = 5'd16;
    localparam logic [4:0] S_RESP  = 5'd17;

    logic [4:0] r_state;
    logic [4:0] n_state;
    logic       in_acc;

    assign o_in_ready = (r_state == S_IDLE) && !i_sts.cfg_hit;
    assign in_acc     = i_in_valid && o_in_ready;

    always_comb begin
        o_cmd       = '0;
        o_cmd.clr   = (r_state == S_CLEAR);
        o_cmd.load  = in_acc;
        o_cmd.home  = (r_state == S_HOME);
        o_cmd.hlen  = (r_state == S_HLEN);
        o_cmd.ins   = (r_state == S_INS);
        o_cmd.scan  = (r_state == S_SCAN);
        o_cmd.xlast = (r_state == S_XLAST);
        o_cmd.xmove = (r_state == S_XMOVE);
        o_cmd.spl0  = (r_state == S_SPL0);
        o_cmd.spl1  = (r_state == S_SPL1);
        o_cmd.srd   = (r_state == S_SRD) && !i_sts.split_end;
        o_cmd.sdat  = (r_state == S_SDAT);
        o_cmd.swr   = (r_state == S_SWR);
        o_cmd.sfin0 = (r_state == S_SFIN0);
        o_cmd.sfin1 = (r_state == S_SFIN1);
        o_cmd.resp  = (r_state == S_RESP) && i_sts.out_free;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (i_sts.clr_last) n_state = S_IDLE;
            S_IDLE:  if (in_acc) n_state = S_HDIV;
            S_HDIV:  if (!i_sts.div_busy) n_state = S_HOME;
            S_HOME:  n_state = S_HLEN;
            S_HLEN: begin
                case (i_sts.op)
                    OP_INSERT: n_state = S_INS;
                    OP_COUNT:  n_state = S_RESP;
                    default:   n_state = S_SCAN;
                endcase
            end
            S_INS:   n_state = i_sts.ins_split ? S_SPL0 : S_RESP;
            S_SCAN: begin
                if (i_sts.scan_hit) begin
                    n_state = (i_sts.op == OP_EXTRACT) ? S_XLAST : S_RESP;
                end else if (i_sts.scan_end) begin
                    n_state = S_RESP;
                end
            end
            S_XLAST: n_state = S_XMOVE;
            S_XMOVE: n_state = S_RESP;
            S_SPL0:  n_state = S_SPL1;
            S_SPL1:  n_state = S_SRD;
            S_SRD:   n_state = i_sts.split_end ? S_SFIN0 : S_SDAT;
            S_SDAT:  n_state = S_SDIV;
            S_SDIV:  if (!i_sts.div_busy) n_state = S_SWR;
            S_SWR:   n_state = S_SRD;
            S_SFIN0: n_state = S_SFIN1;
            S_SFIN1: n_state = S_RESP;
            S_RESP:  if (i_sts.out_free) n_state = S_IDLE;
            default: n_state = S_CLEAR;
        endcase
        if (i_sts.cfg_hit) begin
            n_state = S_CLEAR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> hdl/lht_dp.sv
// Datapath of the linear hash table: registers, modulo unit, RAMs, result register.
// Depends on lht_pkg and lht_ram.
module lht_dp import lht_pkg::*; #(
    parameter int MAX_BUCKETS = MAX_BUCKETS_DEF,
    parameter int CHAIN_CAP   = CHAIN_CAP_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_in                   i_in,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output t_out                  o_out,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts
);

    localparam int BKW = $clog2(MAX_BUCKETS);
    localparam int BCW = $clog2(MAX_BUCKETS + 1);
    localparam int MW  = $clog2(MAX_BUCKETS) + 2;
    localparam int LW  = $clog2(CHAIN_CAP + 1);
    localparam int SAW = $clog2(MAX_BUCKETS * CHAIN_CAP);
    localparam int PW  = BCW + 7;
    localparam int CW  = BCW + 18;

    function automatic logic [SAW-1:0] slot_addr(input logic [BKW-1:0] b,
                                                 input logic [LW-1:0] s);
        return SAW'(b) * SAW'(CHAIN_CAP) + SAW'(s);
    endfunction

    // configuration
    logic [8:0] r_cfg_init;
    logic [6:0] r_cfg_ent;
    logic       cfg_hit;

    // table state
    logic [BCW-1:0] r_m1;
    logic [BKW-1:0] r_sp;
    logic [BCW-1:0] r_bcnt;
    logic [14:0]    r_count;
    logic [PW-1:0]  r_cap;
    logic [BKW-1:0] r_clr_idx;

    // per-transaction
    logic [1:0]     r_op;
    logic [31:0]    r_key;
    logic [30:0]    r_hash;
    logic [31:0]    r_item;
    logic [1:0]     r_status;
    logic [31:0]    r_found;
    logic [BKW-1:0] r_bkt;
    logic [LW-1:0]  r_len;
    logic [LW-1:0]  r_sidx;
    logic           r_spv;
    logic [LW-1:0]  r_spos;
    logic [LW-1:0]  r_pos;
    logic [LW-1:0]  r_keep;
    logic [LW-1:0]  r_moved;
    t_slot          r_ent;

    // modulo unit
    logic [31:0]   r_dvd;
    logic [MW-1:0] r_rem;
    logic [2:0]    r_dcnt;
    logic          r_drun;
    logic [MW-1:0] mod2;
    logic [MW-1:0] rem_step;
    logic [MW:0]   dtmp;

    // result
    logic r_ov;
    t_out r_out;

    // RAM ports
    logic           len_we;
    logic [BKW-1:0] len_waddr;
    logic [LW-1:0]  len_wdata;
    logic [BKW-1:0] len_raddr;
    logic [LW-1:0]  len_rdata;
    logic           slot_we;
    logic [SAW-1:0] slot_waddr;
    t_slot          slot_wdata;
    logic [SAW-1:0] slot_raddr;
    t_slot          slot_rdata;

    logic [BCW-1:0] eff_init;
    logic [6:0]     eff_ent;
    logic [MW-1:0]  idx1;
    logic [MW-1:0]  home_b;
    logic [BKW-1:0] home_bkt;
    logic           issue;
    logic           ins_ok;
    logic           over;
    logic           at_max;
    logic           keep_it;
    logic [BCW-1:0] bcnt_inc;

    assign cfg_hit = i_cfg_valid &&
                     (i_cfg_index == REG_INITIAL_BUCKETS || i_cfg_index == REG_BUCKET_ENTRIES);

    always_comb begin
        if (r_cfg_init == 9'd0) begin
            eff_init = BCW'(1);
        end else if (32'(r_cfg_init) > MAX_BUCKETS) begin
            eff_init = BCW'(MAX_BUCKETS);
        end else begin
            eff_init = BCW'(r_cfg_init);
        end
        eff_ent = (r_cfg_ent == 7'd0) ? 7'd1 : r_cfg_ent;
    end

    assign mod2 = MW'({r_m1, 1'b0});

    // four remainder bits a cycle
    always_comb begin
        rem_step = r_rem;
        dtmp     = '0;
        for (int k = 0; k < 4; k++) begin
            dtmp = {rem_step, r_dvd[31-k]};
            if (dtmp >= {1'b0, mod2}) begin
                dtmp = dtmp - {1'b0, mod2};
            end
            rem_step = dtmp[MW-1:0];
        end
    end

    always_comb begin
        idx1     = (r_rem >= MW'(r_m1)) ? r_rem - MW'(r_m1) : r_rem;
        home_b   = (idx1 < MW'(r_sp)) ? r_rem : idx1;
        home_bkt = home_b[BKW-1:0];
    end

    assign issue    = r_sidx < r_len;
    assign over     = CW'({r_count, 2'b00}) > (CW'(r_cap) + CW'({r_cap, 1'b0}));
    assign at_max   = 32'(r_bcnt) >= MAX_BUCKETS;
    assign ins_ok   = (r_count != COUNT_MAX) && (32'(r_len) < CHAIN_CAP);
    assign keep_it  = r_rem == MW'(r_sp);
    assign bcnt_inc = r_bcnt + BCW'(1);

    always_comb begin
        o_sts           = '0;
        o_sts.cfg_hit   = cfg_hit;
        o_sts.clr_last  = 32'(r_clr_idx) == MAX_BUCKETS - 1;
        o_sts.div_busy  = r_drun;
        o_sts.op        = r_op;
        o_sts.scan_hit  = r_spv && (slot_rdata.key == r_key);
        o_sts.scan_end  = !r_spv && !issue;
        o_sts.ins_split = ins_ok && over && !at_max;
        o_sts.split_end = !issue;
        o_sts.out_free  = !r_ov || i_out_ready;
    end

    // RAM port selection
    always_comb begin
        len_we     = 1'b0;
        len_waddr  = r_bkt;
        len_wdata  = '0;
        len_raddr  = i_cmd.spl0 ? r_sp : home_bkt;
        slot_we    = 1'b0;
        slot_waddr = slot_addr(r_bkt, r_len);
        slot_wdata = '{key: r_key, hash: r_hash, item: r_item};
        slot_raddr = slot_addr(r_bkt, r_sidx);
        if (i_cmd.clr) begin
            len_we    = 1'b1;
            len_waddr = r_clr_idx;
        end
        if (i_cmd.ins && ins_ok) begin
            slot_we   = 1'b1;
            len_we    = !(over && at_max);
            len_wdata = r_len + LW'(1);
        end
        if (i_cmd.xlast) begin
            slot_raddr = slot_addr(r_bkt, r_len - LW'(1));
        end
        if (i_cmd.xmove) begin
            slot_we    = 1'b1;
            slot_waddr = slot_addr(r_bkt, r_pos);
            slot_wdata = slot_rdata;
            len_we     = 1'b1;
            len_wdata  = r_len - LW'(1);
        end
        if (i_cmd.srd) begin
            slot_raddr = slot_addr(r_sp, r_sidx);
        end
        if (i_cmd.swr) begin
            slot_we    = 1'b1;
            slot_wdata = r_ent;
            slot_waddr = keep_it ? slot_addr(r_sp, r_keep)
                                 : slot_addr(r_bcnt[BKW-1:0], r_moved);
        end
        if (i_cmd.sfin0) begin
            len_we    = 1'b1;
            len_waddr = r_sp;
            len_wdata = r_keep;
        end
        if (i_cmd.sfin1) begin
            len_we    = 1'b1;
            len_waddr = r_bcnt[BKW-1:0];
            len_wdata = r_moved;
        end
    end

    lht_ram #(.WIDTH(LW), .DEPTH(MAX_BUCKETS)) u_len_ram (
        .i_clk   (i_clk),
        .i_we    (len_we),
        .i_waddr (len_waddr),
        .i_wdata (len_wdata),
        .i_raddr (len_raddr),
        .o_rdata (len_rdata)
    );

    lht_ram #(.WIDTH($bits(t_slot)), .DEPTH(MAX_BUCKETS * CHAIN_CAP)) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (slot_we),
        .i_waddr (slot_waddr),
        .i_wdata (slot_wdata),
        .i_raddr (slot_raddr),
        .o_rdata (slot_rdata)
    );

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_init <= 9'd4;
            r_cfg_ent  <= 7'd4;
            r_clr_idx  <= '0;
            r_drun     <= 1'b0;
            r_dcnt     <= '0;
            r_ov       <= 1'b0;
            r_m1       <= BCW'(4);
            r_bcnt     <= BCW'(4);
            r_sp       <= '0;
            r_count    <= '0;
        end else begin
            if (cfg_hit) begin
                if (i_cfg_index == REG_INITIAL_BUCKETS) begin
                    r_cfg_init <= i_cfg_data;
                end else begin
                    r_cfg_ent <= i_cfg_data[6:0];
                end
                r_clr_idx <= '0;
            end else if (i_cmd.clr) begin
                r_clr_idx <= r_clr_idx + BKW'(1);
            end
            if (i_cmd.clr) begin
                r_m1    <= eff_init;
                r_bcnt  <= eff_init;
                r_sp    <= '0;
                r_count <= '0;
            end
            if (i_cmd.load || i_cmd.sdat) begin
                r_drun <= 1'b1;
                r_dcnt <= '0;
            end else if (r_drun) begin
                r_dcnt <= r_dcnt + 3'd1;
                if (r_dcnt == 3'd7) begin
                    r_drun <= 1'b0;
                end
            end
            if (i_cmd.ins && ins_ok && !(over && at_max)) begin
                r_count <= r_count + 15'd1;
            end
            if (i_cmd.xmove && r_count != 15'd0) begin
                r_count <= r_count - 15'd1;
            end
            if (i_cmd.sfin1) begin
                r_bcnt <= bcnt_inc;
                if (MW'(bcnt_inc) == mod2) begin
                    r_m1 <= BCW'({r_m1, 1'b0});
                    r_sp <= '0;
                end else begin
                    r_sp <= r_sp + BKW'(1);
                end
            end
            if (i_cmd.resp) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cap <= PW'(r_bcnt) * PW'(eff_ent);
        if (i_cmd.load) begin
            r_op     <= i_in.operation;
            r_key    <= i_in.key;
            r_hash   <= i_in.key_hash;
            r_item   <= i_in.item_value;
            r_status <= ST_OK;
            r_found  <= '0;
            r_dvd    <= {1'b0, i_in.key_hash};
            r_rem    <= '0;
        end else if (i_cmd.sdat) begin
            r_ent <= slot_rdata;
            r_dvd <= {1'b0, slot_rdata.hash};
            r_rem <= '0;
        end else if (r_drun) begin
            r_dvd <= {r_dvd[27:0], 4'd0};
            r_rem <= rem_step;
        end
        if (i_cmd.home) begin
            r_bkt <= home_bkt;
        end
        if (i_cmd.hlen || i_cmd.spl1) begin
            r_len  <= len_rdata;
            r_sidx <= '0;
            r_spv  <= 1'b0;
        end
        if (i_cmd.spl0) begin
            r_keep  <= '0;
            r_moved <= '0;
        end
        if (i_cmd.ins) begin
            if (r_count == COUNT_MAX) begin
                r_status <= ST_TABLE_FULL;
            end else if (32'(r_len) >= CHAIN_CAP) begin
                r_status <= ST_CHAIN_FULL;
            end else if (over && at_max) begin
                r_status <= ST_TABLE_FULL;
            end
        end
        if (i_cmd.scan) begin
            r_spv  <= issue;
            r_spos <= r_sidx;
            if (issue) begin
                r_sidx <= r_sidx + LW'(1);
            end
            if (o_sts.scan_hit) begin
                r_found <= slot_rdata.item;
                r_pos   <= r_spos;
            end else if (o_sts.scan_end) begin
                r_status <= ST_NOT_FOUND;
            end
        end
        if (i_cmd.swr) begin
            r_sidx <= r_sidx + LW'(1);
            if (keep_it) begin
                r_keep <= r_keep + LW'(1);
            end else begin
                r_moved <= r_moved + LW'(1);
            end
        end
        if (i_cmd.resp) begin
            r_out.status       <= r_status;
            r_out.found_item   <= r_found;
            r_out.stored_count <= r_count;
        end
    end

    assign o_out_valid = r_ov;
    assign o_out       = r_out;

endmodule

>>> bench/tb_linear_hash_table.sv
// Self-checking testbench for linear_hash_table: directed and random transactions,
// checked against a behavioural model of the linear-hashing table held in the bench.
// Depends on lht_pkg and the linear_hash_table RTL.
module tb_linear_hash_table;
    import lht_pkg::*;

    localparam int NBKT      = MAX_BUCKETS_DEF;
    localparam int NSLOT     = CHAIN_CAP_DEF;
    localparam int STALL_MAX = 20000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  in_vld = 1'b0;
    logic                  in_rdy;
    t_in                   in_bus = '0;
    logic                  out_vld;
    logic                  out_rdy = 1'b0;
    t_out                  out_bus;
    logic                  cfg_vld = 1'b0;
    logic                  cfg_rdy;
    logic [CFG_IDX_W-1:0]  cfg_idx = '0;
    logic [CFG_DATA_W-1:0] cfg_dat = '0;

    linear_hash_table i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_vld),
        .o_in_ready  (in_rdy),
        .i_in        (in_bus),
        .o_out_valid (out_vld),
        .i_out_ready (out_rdy),
        .o_out       (out_bus),
        .i_cfg_valid (cfg_vld),
        .o_cfg_ready (cfg_rdy),
        .i_cfg_index (cfg_idx),
        .i_cfg_data  (cfg_dat)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Mirror of the table: registers, slots and chain bookkeeping
    logic [8:0]  tbl_ib = 9'd4;
    logic [6:0]  tbl_be = 7'd4;
    logic [31:0] mir_key  [NBKT*NSLOT];
    logic [30:0] mir_hash [NBKT*NSLOT];
    logic [31:0] mir_item [NBKT*NSLOT];
    int unsigned mir_len  [NBKT];
    int unsigned mir_round, mir_ptr, mir_bkts, mir_count;

    t_in  ops_pending [$];
    t_out results_due [$];
    int   send_idle = 0;
    int   recv_idle = 0;
    int   fail_cnt  = 0;
    logic in_taken  = 1'b0;
    bit   run_on    = 1'b0;

    function automatic int unsigned eff_ib();
        if (tbl_ib == 0) return 1;
        if (tbl_ib > NBKT) return NBKT;
        return tbl_ib;
    endfunction

    function automatic longint unsigned modulus(int unsigned r);
        if (r > 40) r = 40;
        return longint'(eff_ib()) << r;
    endfunction

    function automatic void empty_table();
        for (int b = 0; b < NBKT; b++) mir_len[b] = 0;
        mir_round = 0;
        mir_ptr   = 0;
        mir_bkts  = eff_ib();
        mir_count = 0;
    endfunction

    function automatic int unsigned home_of(logic [30:0] h);
        longint unsigned idx;
        idx = longint'(h) % modulus(mir_round);
        if (idx < mir_ptr) idx = longint'(h) % modulus(mir_round + 1);
        if (idx >= mir_bkts || idx >= NBKT) idx = 0;
        return int'(idx);
    endfunction

    // Split the pointer bucket: stayers keep their order, movers fill the new bucket
    function automatic void split_ptr_bucket();
        longint unsigned m2;
        int unsigned p, nb, keep, moved, s, d;
        p = mir_ptr;
        nb = mir_bkts;
        m2 = modulus(mir_round + 1);
        keep = 0;
        moved = 0;
        for (int i = 0; i < mir_len[p]; i++) begin
            s = p * NSLOT + i;
            if (longint'(mir_hash[s]) % m2 == p) begin
                d = p * NSLOT + keep;
                keep++;
            end else begin
                d = nb * NSLOT + moved;
                moved++;
            end
            mir_key[d]  = mir_key[s];
            mir_hash[d] = mir_hash[s];
            mir_item[d] = mir_item[s];
        end
        mir_len[p]  = keep;
        mir_len[nb] = moved;
        mir_bkts    = nb + 1;
        if (longint'(mir_bkts) == m2) begin
            mir_round++;
            mir_ptr = 0;
        end else begin
            mir_ptr++;
        end
    endfunction

    function automatic t_out table_op(t_in t);
        t_out r;
        int unsigned b, base, n, ent, pos, last;
        bit hit;
        r = '0;
        r.status = ST_OK;
        b = home_of(t.key_hash);
        base = b * NSLOT;
        n = mir_len[b];
        ent = (tbl_be == 0) ? 1 : tbl_be;
        if (t.operation == OP_INSERT) begin
            if (mir_count >= COUNT_MAX) begin
                r.status = ST_TABLE_FULL;
            end else if (n >= NSLOT) begin
                r.status = ST_CHAIN_FULL;
            end else begin
                mir_key[base+n]  = t.key;
                mir_hash[base+n] = t.key_hash;
                mir_item[base+n] = t.item_value;
                mir_len[b] = n + 1;
                if (4 * longint'(mir_count) > 3 * longint'(mir_bkts) * ent) begin
                    if (mir_bkts >= NBKT) begin
                        mir_len[b] = n;
                        r.status = ST_TABLE_FULL;
                    end else begin
                        split_ptr_bucket();
                    end
                end
                if (r.status == ST_OK) mir_count++;
            end
        end else if (t.operation == OP_LOOKUP || t.operation == OP_EXTRACT) begin
            hit = 1'b0;
            pos = 0;
            for (int i = 0; i < n && !hit; i++) begin
                if (mir_key[base+i] == t.key) begin
                    hit = 1'b1;
                    pos = i;
                end
            end
            if (!hit) begin
                r.status = ST_NOT_FOUND;
            end else begin
                r.found_item = mir_item[base+pos];
                if (t.operation == OP_EXTRACT) begin
                    last = base + n - 1;
                    mir_key[base+pos]  = mir_key[last];
                    mir_hash[base+pos] = mir_hash[last];
                    mir_item[base+pos] = mir_item[last];
                    mir_len[b] = n - 1;
                    if (mir_count > 0) mir_count--;
                end
            end
        end
        r.stored_count = mir_count[14:0];
        return r;
    endfunction

    // Driver: advance to the next item once the current one is taken
    always @(negedge i_clk) begin
        if (run_on) begin
            if (!in_vld || in_taken) begin
                if (ops_pending.size() > 0 && $urandom_range(99) >= send_idle) begin
                    in_bus <= ops_pending.pop_front();
                    in_vld <= 1'b1;
                end else begin
                    in_vld <= 1'b0;
                end
            end
            out_rdy <= ($urandom_range(99) >= recv_idle);
        end
    end

    // Monitor: predict on accepted input, check on accepted output, watch for hangs
    int stall_cnt = 0;
    t_out want;
    always @(posedge i_clk) begin
        in_taken <= in_vld && in_rdy;
        if (i_rst_n) begin
            if (cfg_vld && cfg_rdy) begin
                if (cfg_idx == REG_INITIAL_BUCKETS) tbl_ib = cfg_dat[8:0];
                else if (cfg_idx == REG_BUCKET_ENTRIES) tbl_be = cfg_dat[6:0];
                empty_table();
            end
            if (in_vld && in_rdy) results_due.push_back(table_op(in_bus));
            if (out_vld && out_rdy) begin
                if (results_due.size() == 0) begin
                    $error("unexpected result: status %0d item %h count %0d",
                           out_bus.status, out_bus.found_item, out_bus.stored_count);
                    fail_cnt++;
                end else begin
                    want = results_due.pop_front();
                    if (out_bus.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, out_bus.status);
                        fail_cnt++;
                    end
                    if (out_bus.found_item !== want.found_item) begin
                        $error("found_item: expected %h, got %h",
                               want.found_item, out_bus.found_item);
                        fail_cnt++;
                    end
                    if (out_bus.stored_count !== want.stored_count) begin
                        $error("stored_count: expected %0d, got %0d",
                               want.stored_count, out_bus.stored_count);
                        fail_cnt++;
                    end
                end
            end
            if ((in_vld && in_rdy) || (out_vld && out_rdy) || (cfg_vld && cfg_rdy))
                stall_cnt <= 0;
            else
                stall_cnt <= stall_cnt + 1;
            if (stall_cnt >= STALL_MAX) begin
                $display("linear_hash_table regression: fail");
                $finish;
            end
        end
    end

    task automatic queue_op(logic [1:0] op, logic [31:0] k, logic [30:0] h, logic [31:0] v);
        t_in t;
        t.operation  = op;
        t.key        = k;
        t.key_hash   = h;
        t.item_value = v;
        ops_pending.push_back(t);
    endtask

    // Mostly keys from a small pool with a hash tied to the key, so lookups and
    // extracts hit; the rest is fully random
    task automatic queue_random(int count, int ins_pct, int pool);
        int r;
        logic [1:0] op;
        logic [31:0] k;
        logic [30:0] h;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(99);
            if (r < ins_pct) op = OP_INSERT;
            else if (r < ins_pct + (100 - ins_pct) * 4 / 10) op = OP_LOOKUP;
            else if (r < ins_pct + (100 - ins_pct) * 8 / 10) op = OP_EXTRACT;
            else op = OP_COUNT;
            k = ($urandom_range(99) < 85) ? $urandom_range(pool) : $urandom;
            h = ($urandom_range(99) < 80) ? (k[30:0] * 31'd2654435) ^ {k[31], 30'd0}
                                          : 31'($urandom);
            queue_op(op, k, h, $urandom);
        end
    endtask

    task automatic drain();
        do @(posedge i_clk);
        while (ops_pending.size() != 0 || in_vld || results_due.size() != 0);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [8:0] val);
        @(negedge i_clk);
        cfg_idx <= idx;
        cfg_dat <= val;
        cfg_vld <= 1'b1;
        do @(posedge i_clk);
        while (!cfg_rdy);
        @(negedge i_clk);
        cfg_vld <= 1'b0;
    endtask

    task automatic set_table(logic [8:0] ib, logic [6:0] be);
        drain();
        write_reg(REG_INITIAL_BUCKETS, ib);
        write_reg(REG_BUCKET_ENTRIES, {2'b00, be});
    endtask

    initial begin
        empty_table();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        run_on  = 1'b1;

        // Sender idles lightly, receiver heavily
        send_idle = 7;
        recv_idle = 87;
        // Directed: empty table, field extremes, duplicates, hole fill
        queue_op(OP_COUNT,   32'hFFFF_FFFF, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
        queue_op(OP_LOOKUP,  32'h0,         31'h0,         32'h0);
        queue_op(OP_EXTRACT, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 32'h0);
        queue_op(OP_INSERT,  32'h0,         31'h0,         32'hFFFF_FFFF);
        queue_op(OP_INSERT,  32'hFFFF_FFFF, 31'h7FFF_FFFF, 32'h0);
        queue_op(OP_INSERT,  32'h0,         31'h4,         32'h1);
        queue_op(OP_INSERT,  32'h9,         31'h8,         32'h99);
        queue_op(OP_LOOKUP,  32'h0,         31'h0,         32'h0);
        queue_op(OP_EXTRACT, 32'h0,         31'h0,         32'h0);
        queue_op(OP_LOOKUP,  32'h0,         31'h0,         32'h0);
        queue_op(OP_LOOKUP,  32'h9,         31'h8,         32'h0);
        queue_op(OP_LOOKUP,  32'hFFFF_FFFF, 31'h7FFF_FFFF, 32'h0);
        for (int i = 1; i <= 8; i++) queue_op(OP_INSERT, 32'(i * 3), 31'(i), 32'(i * 17));
        queue_op(OP_EXTRACT, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 32'h0);
        queue_op(OP_LOOKUP,  32'h6,         31'h2,         32'h0);
        queue_op(OP_COUNT,   32'h0,         31'h0,         32'h0);
        // Hold off until every result is back before continuing
        drain();
        queue_random(120, 45, 63);

        // Zero registers act as one initial bucket with one entry per bucket
        set_table(9'd0, 7'd0);
        queue_random(200, 45, 63);

        // Receiver idles lightly, sender heavily; fill a maximal table until it refuses
        send_idle = 87;
        recv_idle = 7;
        set_table(9'd256, 7'd1);
        queue_random(230, 85, 4000);

        // One long chain: all entries on one hash until the chain is full
        set_table(9'd4, 7'd64);
        for (int i = 0; i < 66; i++) queue_op(OP_INSERT, $urandom_range(40), 31'h0, $urandom);
        for (int i = 0; i < 10; i++) queue_op(OP_EXTRACT, $urandom_range(40), 31'h0, 32'h0);
        queue_random(60, 45, 63);

        // No idling on either side
        send_idle = 0;
        recv_idle = 0;
        set_table(9'd511, 7'd127);
        queue_random(160, 50, 255);
        set_table(9'd3, 7'd2);
        queue_random(290, 50, 127);

        drain();
        repeat (20) @(posedge i_clk);
        if (fail_cnt == 0) begin
            $display("linear_hash_table regression: pass");
        end else begin
            $display("linear_hash_table regression: fail");
        end
        $finish;
    end
endmodule
